### rtl/assert_macros.svh
// assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is held
`define NSC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked around reset
`define NSC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/nsc_pkg.sv
// ---------------------------------------------------------------------------
// nsc_pkg
// Types, operation codes and helper functions of the noise sound channel.
// ---------------------------------------------------------------------------
`default_nettype none

package nsc_pkg;

    // Input mode codes
    localparam logic [2:0] MODE_WRITE    = 3'd0;
    localparam logic [2:0] MODE_READ     = 3'd1;
    localparam logic [2:0] MODE_TIMER    = 3'd2;
    localparam logic [2:0] MODE_LENGTH   = 3'd3;
    localparam logic [2:0] MODE_ENVELOPE = 3'd4;
    localparam logic [2:0] MODE_POWEROFF = 3'd5;
    localparam logic [2:0] MODE_RESET    = 3'd6;

    // Register indexes
    localparam logic [2:0] REG_NR0  = 3'd0;
    localparam logic [2:0] REG_NR1  = 3'd1;
    localparam logic [2:0] REG_NR2  = 3'd2;
    localparam logic [2:0] REG_NR3  = 3'd3;
    localparam logic [2:0] REG_NR4  = 3'd4;
    localparam int         NUM_REGS = 5;

    // Operation codes between front and back
    typedef logic [3:0] t_op;
    localparam t_op OP_NOP      = 4'd0;
    localparam t_op OP_WRITE    = 4'd1;
    localparam t_op OP_READ     = 4'd2;
    localparam t_op OP_READ_OOR = 4'd3;
    localparam t_op OP_TIMER    = 4'd4;
    localparam t_op OP_LENGTH   = 4'd5;
    localparam t_op OP_ENVELOPE = 4'd6;
    localparam t_op OP_POWEROFF = 4'd7;
    localparam t_op OP_RESET    = 4'd8;

    // Command queue
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = 1;
    localparam int Q_CW    = 2;

    localparam int PERIOD_W = 22;
    localparam int LFSR_W   = 15;
    localparam logic [LFSR_W-1:0] LFSR_SEED = 15'h7fff;

    typedef struct packed {
        t_op        op;
        logic [2:0] idx;
        logic [7:0] data;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // Frequency timer period: (div ? div*16 : 8) << shift
    function automatic logic [PERIOD_W-1:0] period_of(input logic [2:0] div,
                                                      input logic [3:0] sh);
        logic [PERIOD_W-1:0] base;
        base = (div != 3'd0) ? {15'd0, div, 4'd0} : 22'd8;
        return base << sh;
    endfunction

    // Bits that always read back as one
    function automatic logic [7:0] read_mask(input logic [2:0] idx);
        logic [7:0] m;
        unique case (idx)
            REG_NR0: m = 8'hff;
            REG_NR1: m = 8'hff;
            REG_NR4: m = 8'hbf;
            default: m = 8'h00;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

### rtl/nsc_ifs.sv
// ---------------------------------------------------------------------------
// nsc_ifs
// Valid/ready channel interfaces for the command and result streams.
// ---------------------------------------------------------------------------
`default_nettype none

interface nsc_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] mode;
    logic [2:0] reg_index;
    logic [7:0] write_data;

    modport source (output valid, mode, reg_index, write_data, input ready);
    modport sink   (input valid, mode, reg_index, write_data, output ready);
endinterface

interface nsc_out_if;
    logic              valid;
    logic              ready;
    logic        [7:0] read_data;
    logic signed [4:0] sample_level;
    logic              channel_on;

    modport source (output valid, read_data, sample_level, channel_on, input ready);
    modport sink   (input valid, read_data, sample_level, channel_on, output ready);
endinterface

`default_nettype wire

### rtl/nsc_front.sv
// ---------------------------------------------------------------------------
// nsc_front
// Accepts command transactions and classifies them into queue commands.
// ---------------------------------------------------------------------------
`default_nettype none

module nsc_front (
    nsc_in_if.sink          i_in,
    input  nsc_pkg::t_q_stat i_qs,
    output logic            o_push,
    output nsc_pkg::t_cmd   o_cmd
);

    logic idx_ok;

    // Take a transaction whenever the queue has room
    assign i_in.ready = !i_qs.full;
    assign o_push     = i_in.valid && !i_qs.full;
    assign idx_ok     = (i_in.reg_index <= nsc_pkg::REG_NR4);

    // Classify; a write to a missing register does nothing
    always_comb begin
        o_cmd.idx  = i_in.reg_index;
        o_cmd.data = i_in.write_data;
        unique case (i_in.mode)
            nsc_pkg::MODE_WRITE:    o_cmd.op = idx_ok ? nsc_pkg::OP_WRITE : nsc_pkg::OP_NOP;
            nsc_pkg::MODE_READ:     o_cmd.op = idx_ok ? nsc_pkg::OP_READ
                                                      : nsc_pkg::OP_READ_OOR;
            nsc_pkg::MODE_TIMER:    o_cmd.op = nsc_pkg::OP_TIMER;
            nsc_pkg::MODE_LENGTH:   o_cmd.op = nsc_pkg::OP_LENGTH;
            nsc_pkg::MODE_ENVELOPE: o_cmd.op = nsc_pkg::OP_ENVELOPE;
            nsc_pkg::MODE_POWEROFF: o_cmd.op = nsc_pkg::OP_POWEROFF;
            nsc_pkg::MODE_RESET:    o_cmd.op = nsc_pkg::OP_RESET;
            default:                o_cmd.op = nsc_pkg::OP_NOP;
        endcase
    end

endmodule

`default_nettype wire

### rtl/nsc_queue.sv
// ---------------------------------------------------------------------------
// nsc_queue
// Two-entry command queue between front and back.
// ---------------------------------------------------------------------------
`default_nettype none

module nsc_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  nsc_pkg::t_cmd     i_cmd,
    input  logic              i_pop,
    output nsc_pkg::t_cmd     o_cmd,
    output nsc_pkg::t_q_stat  o_qs
);

    nsc_pkg::t_cmd                 r_mem [nsc_pkg::Q_DEPTH];
    logic [nsc_pkg::Q_AW-1:0]      r_wp, n_wp;
    logic [nsc_pkg::Q_AW-1:0]      r_rp, n_rp;
    logic [nsc_pkg::Q_CW-1:0]      r_cnt, n_cnt;

    assign o_qs.full  = (r_cnt == nsc_pkg::Q_CW'(nsc_pkg::Q_DEPTH));
    assign o_qs.empty = (r_cnt == '0);
    assign o_cmd      = r_mem[r_rp];

    // Pointer and fill count update
    always_comb begin
        n_wp  = i_push ? r_wp + 1'b1 : r_wp;
        n_rp  = i_pop  ? r_rp + 1'b1 : r_rp;
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

### rtl/nsc_back.sv
// ---------------------------------------------------------------------------
// nsc_back
// Executes queued commands on the channel state and registers each result.
// ---------------------------------------------------------------------------
`default_nettype none

module nsc_back #(
    parameter int LENGTH_MAX = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  nsc_pkg::t_cmd     i_cmd,
    input  nsc_pkg::t_q_stat  i_qs,
    output logic              o_pop,
    nsc_out_if.source         o_out
);

    localparam int LW = $clog2(LENGTH_MAX + 1);
    localparam int PW = nsc_pkg::PERIOD_W;
    localparam int SW = nsc_pkg::LFSR_W;

    // Channel state
    logic [7:0]    r_regs [nsc_pkg::NUM_REGS];
    logic [7:0]    n_regs [nsc_pkg::NUM_REGS];
    logic          r_en, n_en;
    logic [LW-1:0] r_len, n_len;
    logic [2:0]    r_env, n_env;
    logic [PW-1:0] r_period, n_period;
    logic [SW-1:0] r_lfsr, n_lfsr;
    logic [3:0]    r_level, n_level;

    // Result register
    logic              r_out_valid;
    logic [7:0]        r_rd, n_rd;
    logic signed [4:0] r_smp, n_smp;
    logic              r_on;

    logic [7:0]    nr2, nr3, nr4;
    logic [5:0]    len_field;
    logic [PW-1:0] per_dec;
    logic          fb;
    logic [2:0]    pace;

    assign nr2       = r_regs[nsc_pkg::REG_NR2];
    assign nr3       = r_regs[nsc_pkg::REG_NR3];
    assign nr4       = r_regs[nsc_pkg::REG_NR4];
    assign len_field = i_cmd.data[5:0];
    assign per_dec   = (r_period != '0) ? r_period - 1'b1 : '0;
    assign fb        = r_lfsr[0] ^ r_lfsr[1];
    assign pace      = nr2[2:0];

    // Dequeue when the result slot is free or being drained
    assign o_pop = !i_qs.empty && (!r_out_valid || o_out.ready);

    // Command execution
    always_comb begin
        n_regs   = r_regs;
        n_en     = r_en;
        n_len    = r_len;
        n_env    = r_env;
        n_period = r_period;
        n_lfsr   = r_lfsr;
        n_level  = r_level;
        n_rd     = 8'h00;
        unique case (i_cmd.op)
            nsc_pkg::OP_WRITE: begin
                n_regs[i_cmd.idx] = i_cmd.data;
                unique case (i_cmd.idx)
                    nsc_pkg::REG_NR1: begin
                        // saturate at zero when field exceeds the maximum
                        if (int'(len_field) > LENGTH_MAX) begin
                            n_len = '0;
                        end else begin
                            n_len = LW'(LENGTH_MAX - int'(len_field));
                        end
                    end
                    nsc_pkg::REG_NR2: begin
                        n_level = i_cmd.data[7:4];
                        n_env   = i_cmd.data[2:0];
                        if (i_cmd.data[7:3] == 5'd0) begin
                            n_en = 1'b0;
                        end
                    end
                    nsc_pkg::REG_NR3: begin
                        // old divider, new shift
                        n_period = nsc_pkg::period_of(nr3[2:0], i_cmd.data[7:4]);
                    end
                    nsc_pkg::REG_NR4: begin
                        if (i_cmd.data[7]) begin
                            n_en = (nr2[7:3] != 5'd0);
                            if (r_len == '0) begin
                                n_len = LW'(LENGTH_MAX);
                            end
                            n_period = nsc_pkg::period_of(nr3[2:0], nr3[7:4]);
                            n_env    = nr2[2:0];
                            n_level  = nr2[7:4];
                            n_lfsr   = nsc_pkg::LFSR_SEED;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            nsc_pkg::OP_READ: begin
                n_rd = r_regs[i_cmd.idx] | nsc_pkg::read_mask(i_cmd.idx);
            end
            nsc_pkg::OP_READ_OOR: begin
                n_rd = 8'hff;
            end
            nsc_pkg::OP_TIMER: begin
                n_period = per_dec;
                if (per_dec == '0) begin
                    // shift in feedback at the top, and mid tap in short mode
                    n_lfsr = {fb, r_lfsr[SW-1:1]};
                    if (nr3[3]) begin
                        n_lfsr[6] = fb;
                    end
                    n_period = nsc_pkg::period_of(nr3[2:0], nr3[7:4]);
                end
            end
            nsc_pkg::OP_LENGTH: begin
                if (nr4[6]) begin
                    n_len = (r_len != '0) ? r_len - 1'b1 : '0;
                    if (n_len == '0) begin
                        n_en = 1'b0;
                    end
                end
            end
            nsc_pkg::OP_ENVELOPE: begin
                if (pace != 3'd0) begin
                    n_env = (r_env != 3'd0) ? r_env - 1'b1 : 3'd0;
                    if (n_env == 3'd0) begin
                        if (nr2[3] && r_level != 4'hf) begin
                            n_level = r_level + 1'b1;
                        end else if (!nr2[3] && r_level != 4'h0) begin
                            n_level = r_level - 1'b1;
                        end
                        n_env = pace;
                    end
                end
            end
            nsc_pkg::OP_POWEROFF: begin
                for (int i = 0; i < nsc_pkg::NUM_REGS; i++) begin
                    n_regs[i] = 8'h00;
                end
                n_regs[nsc_pkg::REG_NR1] = {2'b00, r_regs[nsc_pkg::REG_NR1][5:0]};
                n_en     = 1'b0;
                n_len    = '0;
                n_env    = '0;
                n_period = '0;
                n_lfsr   = '0;
                n_level  = '0;
            end
            nsc_pkg::OP_RESET: begin
                for (int i = 0; i < nsc_pkg::NUM_REGS; i++) begin
                    n_regs[i] = 8'h00;
                end
                n_en     = 1'b0;
                n_len    = '0;
                n_env    = '0;
                n_period = '0;
                n_lfsr   = '0;
                n_level  = '0;
            end
            default: begin
            end
        endcase

        // Output level from the updated state
        n_smp = 5'sd0;
        if (n_en && n_regs[nsc_pkg::REG_NR2][7:3] != 5'd0) begin
            n_smp = n_lfsr[0] ? -$signed({1'b0, n_level}) : $signed({1'b0, n_level});
        end
    end

    // State and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < nsc_pkg::NUM_REGS; i++) begin
                r_regs[i] <= 8'h00;
            end
            r_en        <= 1'b0;
            r_len       <= '0;
            r_env       <= '0;
            r_period    <= '0;
            r_lfsr      <= '0;
            r_level     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_regs   <= n_regs;
                r_en     <= n_en;
                r_len    <= n_len;
                r_env    <= n_env;
                r_period <= n_period;
                r_lfsr   <= n_lfsr;
                r_level  <= n_level;
            end
            if (o_pop) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rd  <= n_rd;
            r_smp <= n_smp;
            r_on  <= n_en;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.read_data    = r_rd;
    assign o_out.sample_level = r_smp;
    assign o_out.channel_on   = r_on;

endmodule

`default_nettype wire

### rtl/lfsr_noise_sound_channel_core.sv
// ---------------------------------------------------------------------------
// lfsr_noise_sound_channel_core
// Noise sound channel: five byte registers, length, envelope, timer and a
// 15-bit LFSR, driven by a stream of command transactions.
// ---------------------------------------------------------------------------
//  channel  role    payload
//  i_in     sink    mode[2:0], reg_index[2:0], write_data[7:0]
//  o_out    source  read_data[7:0], sample_level[4:0] signed, channel_on
//
//  One transaction per cycle sustained while the result channel is not
//  stalled; each command is held in a queue entry, then executed in the back
//  end into the result register. A two-entry command queue and the result
//  register absorb output stalls; i_in.ready drops only when the queue is full.
//  Synchronous reset clears all channel state and the five byte registers at once.
// ---------------------------------------------------------------------------
`default_nettype none

module lfsr_noise_sound_channel_core #(
    parameter int LENGTH_MAX = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    nsc_in_if.sink     i_in,
    nsc_out_if.source  o_out
);

    logic             push;
    logic             pop;
    nsc_pkg::t_cmd    cmd_in;
    nsc_pkg::t_cmd    cmd_q;
    nsc_pkg::t_q_stat qs;

    // Front: accept and classify
    nsc_front u_front (
        .i_in   (i_in),
        .i_qs   (qs),
        .o_push (push),
        .o_cmd  (cmd_in)
    );

    // Command queue
    nsc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd_in),
        .i_pop   (pop),
        .o_cmd   (cmd_q),
        .o_qs    (qs)
    );

    // Back: execute and register the result
    nsc_back #(
        .LENGTH_MAX (LENGTH_MAX)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_q),
        .i_qs    (qs),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire

### rtl/nsc_checker.sv
// ---------------------------------------------------------------------------
// nsc_checker
// Port-level checks of the noise channel result stream.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module nsc_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic        [7:0] i_read_data,
    input logic signed [4:0] i_sample_level,
    input logic              i_channel_on
);

    // Stalled result holds
    `NSC_ASSERT(a_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_read_data) && $stable(i_sample_level) && $stable(i_channel_on), "result changed while stalled")

    // Level never reaches -16
    `NSC_ASSERT(a_range, i_clk, i_rst_n, i_out_valid |-> i_sample_level != 5'sb10000, "sample out of range")

    // A silent channel gives a zero level
    `NSC_ASSERT(a_silent, i_clk, i_rst_n, i_out_valid && !i_channel_on |-> i_sample_level == 5'sd0, "level from disabled channel")

    // No result right after reset
    `NSC_ASSERT_ALWAYS(a_rst, i_clk, !$past(i_rst_n) |-> !i_out_valid, "result valid after reset")

endmodule

bind lfsr_noise_sound_channel_core nsc_checker u_nsc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_read_data    (o_out.read_data),
    .i_sample_level (o_out.sample_level),
    .i_channel_on   (o_out.channel_on)
);

`default_nettype wire

### tb/lfsr_noise_sound_channel_core_test.sv
// ---------------------------------------------------------------------------
// lfsr_noise_sound_channel_core_test
// Self-checking bench for the noise sound channel. Command transactions go
// in through the input channel with random gaps, while the result channel
// is stalled at random. A cycle-free model of the channel (registers,
// length, envelope, timer and LFSR) predicts every result, and each result
// transaction is compared field by field against the oldest prediction.
// ---------------------------------------------------------------------------
`default_nettype none

module lfsr_noise_sound_channel_core_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int         LENGTH_MAX  = 64;
    localparam logic [2:0] MODE_UNUSED = 3'd7;
    localparam logic [2:0] REG_OOR_LO  = 3'd5;
    localparam logic [2:0] REG_OOR_HI  = 3'd7;
    localparam int         PRINT_CAP   = 40;

    typedef struct packed {
        logic [7:0]        read_data;
        logic signed [4:0] sample_level;
        logic              channel_on;
    } t_chan_result;

    logic i_clk;
    logic i_rst_n;

    nsc_in_if  in_if ();
    nsc_out_if out_if ();

    lfsr_noise_sound_channel_core #(
        .LENGTH_MAX(LENGTH_MAX)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    // Shadow copy of the channel state
    logic [7:0]  m_regs [nsc_pkg::NUM_REGS];
    logic        m_enabled;
    logic [6:0]  m_length;
    logic [2:0]  m_env;
    logic [21:0] m_period;
    logic [15:0] m_lfsr;
    logic [3:0]  m_volume;

    t_chan_result channel_outputs_q[$];
    int           error_count  = 0;
    int           result_index = 0;
    int           sent_count   = 0;
    int           next_gap     = 0;
    bit           bus_held     = 1'b0;
    bit           idle_on      = 1'b1;
    bit           stall_on     = 1'b1;
    bit           ready_high   = 1'b0;

    // -----------------------------------------------------------------------
    // Channel model
    // -----------------------------------------------------------------------
    function automatic logic [21:0] noise_period(input logic [2:0] div, input logic [3:0] sh);
        logic [21:0] base;
        base = (div == 3'd0) ? 22'd8 : {15'd0, div, 4'b0000};
        return base << sh;
    endfunction

    function automatic logic dac_enabled();
        return m_regs[nsc_pkg::REG_NR2][7:3] != 5'd0;
    endfunction

    function automatic logic [7:0] always_one_bits(input logic [2:0] idx);
        case (idx)
            nsc_pkg::REG_NR0, nsc_pkg::REG_NR1: return 8'hff;
            nsc_pkg::REG_NR4:                   return 8'hbf;
            default:                            return 8'h00;
        endcase
    endfunction

    function automatic void clear_channel_state();
        m_enabled = 1'b0;
        m_length  = '0;
        m_env     = '0;
        m_period  = '0;
        m_lfsr    = '0;
        m_volume  = '0;
        for (int i = 0; i < nsc_pkg::NUM_REGS; i++) m_regs[i] = 8'h00;
    endfunction

    function automatic void restart_channel();
        m_enabled = dac_enabled();
        if (m_length == 7'd0) m_length = 7'(LENGTH_MAX);
        m_period = noise_period(m_regs[nsc_pkg::REG_NR3][2:0], m_regs[nsc_pkg::REG_NR3][7:4]);
        m_env    = m_regs[nsc_pkg::REG_NR2][2:0];
        m_volume = m_regs[nsc_pkg::REG_NR2][7:4];
        m_lfsr   = 16'h7fff;
    endfunction

    // Apply one command to the model and return the result it yields
    function automatic t_chan_result predict_channel(input logic [2:0] mode,
                                                     input logic [2:0] idx,
                                                     input logic [7:0] data);
        t_chan_result      r;
        logic [2:0]        prev_div;
        logic [2:0]        pace;
        logic [5:0]        keep;
        logic              fb;
        logic              up;
        logic signed [4:0] mag;
        r = '0;
        case (mode)
            nsc_pkg::MODE_WRITE: begin
                if (idx < nsc_pkg::NUM_REGS) begin
                    prev_div = m_regs[nsc_pkg::REG_NR3][2:0];
                    m_regs[idx] = data;
                    case (idx)
                        nsc_pkg::REG_NR1: begin
                            if (int'(data[5:0]) > LENGTH_MAX) m_length = 7'd0;
                            else m_length = 7'(LENGTH_MAX - int'(data[5:0]));
                        end
                        nsc_pkg::REG_NR2: begin
                            m_volume = data[7:4];
                            m_env    = data[2:0];
                            if (!dac_enabled()) m_enabled = 1'b0;
                        end
                        // reload uses the divider held before this write
                        nsc_pkg::REG_NR3: m_period = noise_period(prev_div, data[7:4]);
                        nsc_pkg::REG_NR4: if (data[7]) restart_channel();
                        default: ;
                    endcase
                end
            end
            nsc_pkg::MODE_READ: begin
                r.read_data = (idx < nsc_pkg::NUM_REGS) ? (m_regs[idx] | always_one_bits(idx))
                                                        : 8'hff;
            end
            nsc_pkg::MODE_TIMER: begin
                if (m_period != 22'd0) m_period = m_period - 22'd1;
                if (m_period == 22'd0) begin
                    fb = m_lfsr[0] ^ m_lfsr[1];
                    m_lfsr[15] = fb;
                    if (m_regs[nsc_pkg::REG_NR3][3]) m_lfsr[7] = fb;
                    m_lfsr   = m_lfsr >> 1;
                    m_period = noise_period(m_regs[nsc_pkg::REG_NR3][2:0],
                                            m_regs[nsc_pkg::REG_NR3][7:4]);
                end
            end
            nsc_pkg::MODE_LENGTH: begin
                if (m_regs[nsc_pkg::REG_NR4][6]) begin
                    if (m_length != 7'd0) m_length = m_length - 7'd1;
                    if (m_length == 7'd0) m_enabled = 1'b0;
                end
            end
            nsc_pkg::MODE_ENVELOPE: begin
                pace = m_regs[nsc_pkg::REG_NR2][2:0];
                if (pace != 3'd0) begin
                    if (m_env != 3'd0) m_env = m_env - 3'd1;
                    if (m_env == 3'd0) begin
                        up = m_regs[nsc_pkg::REG_NR2][3];
                        if (up && m_volume != 4'hf) m_volume = m_volume + 4'd1;
                        else if (!up && m_volume != 4'h0) m_volume = m_volume - 4'd1;
                        m_env = pace;
                    end
                end
            end
            nsc_pkg::MODE_POWEROFF: begin
                // only the length field of NRx1 survives
                keep = m_regs[nsc_pkg::REG_NR1][5:0];
                clear_channel_state();
                m_regs[nsc_pkg::REG_NR1] = {2'b00, keep};
            end
            nsc_pkg::MODE_RESET: clear_channel_state();
            default: ;
        endcase
        if (m_enabled && dac_enabled()) begin
            mag = {1'b0, m_volume};
            r.sample_level = m_lfsr[0] ? -mag : mag;
        end
        r.channel_on = m_enabled;
        return r;
    endfunction

    // -----------------------------------------------------------------------
    // Clock, limit
    // -----------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin : run_limit
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // -----------------------------------------------------------------------
    // Input side
    // -----------------------------------------------------------------------
    // Send one command transaction; valid stays up when the next gap is zero
    task automatic send_item(input logic [2:0] mode, input logic [2:0] idx,
                             input logic [7:0] data);
        repeat (next_gap) @(posedge i_clk);
        in_if.valid      <= 1'b1;
        in_if.mode       <= mode;
        in_if.reg_index  <= idx;
        in_if.write_data <= data;
        bus_held = 1'b1;
        do @(posedge i_clk); while (!in_if.ready);
        channel_outputs_q.push_back(predict_channel(mode, idx, data));
        sent_count++;
        next_gap = idle_on ? $urandom_range(0, 7) : 0;
        if (next_gap != 0) begin
            in_if.valid <= 1'b0;
            bus_held = 1'b0;
        end
    endtask

    // Hold the input off until every predicted result has come back
    task automatic wait_for_results();
        if (bus_held) begin
            in_if.valid <= 1'b0;
            bus_held = 1'b0;
        end
        while (channel_outputs_q.size() != 0) @(posedge i_clk);
    endtask

    // -----------------------------------------------------------------------
    // Output side
    // -----------------------------------------------------------------------
    // Result ready with a random stall before every transaction
    initial begin : result_ready_drive
        int stall;
        out_if.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = stall_on ? $urandom_range(0, 7) : 0;
            if (stall != 0) begin
                if (ready_high) begin
                    out_if.ready <= 1'b0;
                    ready_high = 1'b0;
                end
                repeat (stall) @(posedge i_clk);
            end
            if (!ready_high) begin
                out_if.ready <= 1'b1;
                ready_high = 1'b1;
            end
            do @(posedge i_clk); while (!(out_if.valid && out_if.ready));
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        if (error_count < PRINT_CAP)
            $display("mismatch at result %0d: %s got %0d expected %0d",
                     result_index, what, got, want);
        error_count++;
    endtask

    // Compare each result transaction with the oldest prediction
    always @(posedge i_clk) begin : result_check
        t_chan_result want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (channel_outputs_q.size() == 0) begin
                report_mismatch("unexpected result, read_data", int'(out_if.read_data), 0);
            end else begin
                want = channel_outputs_q.pop_front();
                if (out_if.read_data !== want.read_data)
                    report_mismatch("read_data", int'(out_if.read_data), int'(want.read_data));
                if (out_if.sample_level !== want.sample_level)
                    report_mismatch("sample_level", int'(out_if.sample_level),
                                    int'(want.sample_level));
                if (out_if.channel_on !== want.channel_on)
                    report_mismatch("channel_on", int'(out_if.channel_on),
                                    int'(want.channel_on));
            end
            result_index++;
        end
    end

    // -----------------------------------------------------------------------
    // Tests
    // -----------------------------------------------------------------------
    // Field extremes, every mode and the corner cases
    task automatic test_directed_cases();
        idle_on  = 1'b1;
        stall_on = 1'b1;
        send_item(nsc_pkg::MODE_WRITE, nsc_pkg::REG_NR0, 8'hff);  // NRx0 stored, no side effect
        send_item(nsc_pkg::MODE_READ, nsc_pkg::REG_NR0, 8'h00);
        send_item(nsc_pkg::MODE_WRITE, nsc_pkg::REG_NR1, 8'h3f);  // length of one
        send_item(nsc_pkg::MODE_WRITE, nsc_pkg::REG_NR2, 8'hf8);  // full volume, up, pace zero
        send_item(nsc_pkg::MODE_WRITE, nsc_pkg::REG_NR3, 8'h08);  // 7-bit LFSR, shortest period
        send_item(nsc_pkg::MODE_WRITE, nsc_pkg::REG_NR4, 8'hc0);  // trigger with length enable
        send_item(nsc_pkg::MODE_READ, nsc_pkg::REG_NR4, 8'hff);
        for (int k = 0; k < 8; k++)
            send_item(nsc_pkg::MODE_TIMER, (k[0] ? REG_OOR_HI : nsc_pkg::REG_NR0),
                      (k[1] ? 8'hff : 8'h00));
        send_item(nsc_pkg::MODE_LENGTH, nsc_pkg::REG_NR4, 8'h55);     // length runs out
        send_item(nsc_pkg::MODE_WRITE, nsc_pkg::REG_NR2, 8'h07);      // DAC off
        send_item(nsc_pkg::MODE_ENVELOPE, nsc_pkg::REG_NR2, 8'haa);
        send_item(nsc_pkg::MODE_READ, REG_OOR_LO, 8'h00);             // out-of-range read
        send_item(nsc_pkg::MODE_WRITE, REG_OOR_HI, 8'hff);            // out-of-range write
        send_item(MODE_UNUSED, nsc_pkg::REG_NR3, 8'h81);
        send_item(nsc_pkg::MODE_WRITE, nsc_pkg::REG_NR3, 8'hf7);      // reload, old divider
        send_item(nsc_pkg::MODE_POWEROFF, nsc_pkg::REG_NR1, 8'h00);
        send_item(nsc_pkg::MODE_READ, nsc_pkg::REG_NR1, 8'h00);
        send_item(nsc_pkg::MODE_RESET, nsc_pkg::REG_NR0, 8'h00);
    endtask

    // Sender stops until the channel has drained, then resumes
    task automatic test_drain_and_resume();
        idle_on  = 1'b0;
        stall_on = 1'b1;
        send_item(nsc_pkg::MODE_WRITE, nsc_pkg::REG_NR2, 8'h3a);
        send_item(nsc_pkg::MODE_WRITE, nsc_pkg::REG_NR3, 8'h00);
        send_item(nsc_pkg::MODE_WRITE, nsc_pkg::REG_NR4, 8'h80);
        for (int k = 0; k < 6; k++) send_item(nsc_pkg::MODE_TIMER, nsc_pkg::REG_NR0, 8'h00);
        wait_for_results();
        for (int k = 0; k < nsc_pkg::NUM_REGS; k++)
            send_item(nsc_pkg::MODE_READ, 3'(k), 8'h00);
        wait_for_results();
    endtask

    // Set up and trigger the channel, then run it with bursts of ticks
    task automatic test_noise_sequences(input int item_budget);
        int         start;
        int         pick;
        logic [7:0] d;
        start = sent_count;
        while (sent_count - start < item_budget) begin
            idle_on  = ($urandom_range(0, 3) != 0);
            stall_on = ($urandom_range(0, 3) != 0);
            // DAC on most of the time
            d = 8'($urandom_range(0, 255));
            if (d[7:3] == 5'd0 && $urandom_range(0, 7) != 0) d[7:4] = 4'($urandom_range(1, 15));
            send_item(nsc_pkg::MODE_WRITE, nsc_pkg::REG_NR2, d);
            // mostly short timer periods so the LFSR moves
            d = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 7) != 0) d = {3'b000, d[4:3], 1'b0, d[1:0]};
            send_item(nsc_pkg::MODE_WRITE, nsc_pkg::REG_NR3, d);
            d = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 1) != 0) d[5:0] = 6'($urandom_range(48, 63));
            send_item(nsc_pkg::MODE_WRITE, nsc_pkg::REG_NR1, d);
            d = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 9) != 0) d[7] = 1'b1;
            send_item(nsc_pkg::MODE_WRITE, nsc_pkg::REG_NR4, d);
            repeat ($urandom_range(10, 40)) begin
                pick = $urandom_range(0, 99);
                if (pick < 55)
                    send_item(nsc_pkg::MODE_TIMER, 3'($urandom_range(0, 7)),
                              8'($urandom_range(0, 255)));
                else if (pick < 70)
                    send_item(nsc_pkg::MODE_LENGTH, 3'($urandom_range(0, 7)),
                              8'($urandom_range(0, 255)));
                else if (pick < 85)
                    send_item(nsc_pkg::MODE_ENVELOPE, 3'($urandom_range(0, 7)),
                              8'($urandom_range(0, 255)));
                else if (pick < 95)
                    send_item(nsc_pkg::MODE_READ, 3'($urandom_range(0, 7)),
                              8'($urandom_range(0, 255)));
                else
                    send_item(nsc_pkg::MODE_WRITE, 3'($urandom_range(0, 4)),
                              8'($urandom_range(0, 255)));
            end
            if ($urandom_range(0, 5) == 0) wait_for_results();
        end
    endtask

    // Unstructured commands, power-off and reset included
    task automatic test_random_items(input int item_budget);
        int         pick;
        logic [2:0] mode;
        idle_on  = 1'b1;
        stall_on = 1'b1;
        repeat (item_budget) begin
            pick = $urandom_range(0, 99);
            if (pick < 3)       mode = nsc_pkg::MODE_POWEROFF;
            else if (pick < 5)  mode = nsc_pkg::MODE_RESET;
            else if (pick < 7)  mode = MODE_UNUSED;
            else                mode = 3'($urandom_range(0, 4));
            if ($urandom_range(0, 19) == 0) stall_on = ~stall_on;
            send_item(mode, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
        end
    endtask

    // -----------------------------------------------------------------------
    // Main sequence
    // -----------------------------------------------------------------------
    initial begin : test_sequence
        in_if.valid      <= 1'b0;
        in_if.mode       <= nsc_pkg::MODE_WRITE;
        in_if.reg_index  <= nsc_pkg::REG_NR0;
        in_if.write_data <= 8'h00;
        i_rst_n          <= 1'b0;
        clear_channel_state();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_cases();
        wait_for_results();
        test_drain_and_resume();
        test_noise_sequences(320);
        wait_for_results();
        test_random_items(90);
        wait_for_results();
        repeat (8) @(posedge i_clk);

        if (error_count == 0 && channel_outputs_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

### sim.f
+incdir+rtl
rtl/nsc_pkg.sv
rtl/nsc_ifs.sv
rtl/nsc_front.sv
rtl/nsc_queue.sv
rtl/nsc_back.sv
rtl/lfsr_noise_sound_channel_core.sv
rtl/nsc_checker.sv
tb/lfsr_noise_sound_channel_core_test.sv
